@@ hdl/ansi_csi_sequence_parser_unit_macros.svh @@
// assertion macros shared by the parser front end and job queue
`ifndef ANSI_CSI_SEQUENCE_PARSER_UNIT_MACROS_SVH
`define ANSI_CSI_SEQUENCE_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent holds, consequent holds in the same cycle
`define ACSP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acsp assertion failed");
// antecedent holds, consequent holds in the next cycle
`define ACSP_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acsp assertion failed");
`else
`define ACSP_ASSERT_IMP(name, clk, rst, ante, cons)
`define ACSP_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

@@ hdl/acsp_pkg.sv @@
// shared constants, types and helpers of the csi sequence parser
package acsp_pkg;

   // parameter store geometry
   localparam int MAX_PARAMS    = 8;
   localparam int PARAM_WIDTH   = 16;
   localparam int OUT_WIDTH     = 16;
   localparam int CNT_WIDTH     = $clog2(MAX_PARAMS + 1);
   localparam int IDX_WIDTH     = $clog2(MAX_PARAMS);
   localparam int DECODE_PARAMS = 5;

   // byte codes
   localparam logic [7:0] BYTE_ESC      = 8'h1B;
   localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
   localparam logic [7:0] BYTE_SEMI     = 8'h3B;
   localparam logic [7:0] BYTE_DIGIT_LO = 8'h30;
   localparam logic [7:0] BYTE_DIGIT_HI = 8'h39;
   localparam logic [7:0] BYTE_UPPER_LO = 8'h41;
   localparam logic [7:0] BYTE_UPPER_HI = 8'h5A;
   localparam logic [7:0] BYTE_LOWER_LO = 8'h61;
   localparam logic [7:0] BYTE_LOWER_HI = 8'h7A;

   // final letters
   localparam logic [7:0] FIN_UP      = 8'h41;
   localparam logic [7:0] FIN_DOWN    = 8'h42;
   localparam logic [7:0] FIN_FWD     = 8'h43;
   localparam logic [7:0] FIN_BACK    = 8'h44;
   localparam logic [7:0] FIN_POS     = 8'h48;
   localparam logic [7:0] FIN_POS_ALT = 8'h66;
   localparam logic [7:0] FIN_CLRSCR  = 8'h4A;
   localparam logic [7:0] FIN_CLRLINE = 8'h4B;
   localparam logic [7:0] FIN_SGR     = 8'h6D;

   // action codes
   localparam logic [3:0] ACT_UP      = 4'd0;
   localparam logic [3:0] ACT_DOWN    = 4'd1;
   localparam logic [3:0] ACT_FWD     = 4'd2;
   localparam logic [3:0] ACT_BACK    = 4'd3;
   localparam logic [3:0] ACT_SETPOS  = 4'd4;
   localparam logic [3:0] ACT_CLRSCR  = 4'd5;
   localparam logic [3:0] ACT_CLRLINE = 4'd6;
   localparam logic [3:0] ACT_RESET   = 4'd7;
   localparam logic [3:0] ACT_FG      = 4'd8;
   localparam logic [3:0] ACT_BG      = 4'd9;
   localparam logic [3:0] ACT_FG256   = 4'd10;
   localparam logic [3:0] ACT_BG256   = 4'd11;
   localparam logic [3:0] ACT_FGRGB   = 4'd12;
   localparam logic [3:0] ACT_BGRGB   = 4'd13;
   localparam logic [3:0] ACT_UNKNOWN = 4'd14;

   // sgr mode values
   localparam logic [PARAM_WIDTH-1:0] SGR_OFF     = PARAM_WIDTH'(0);
   localparam logic [PARAM_WIDTH-1:0] SGR_FG_LO   = PARAM_WIDTH'(30);
   localparam logic [PARAM_WIDTH-1:0] SGR_FG_HI   = PARAM_WIDTH'(37);
   localparam logic [PARAM_WIDTH-1:0] SGR_BG_LO   = PARAM_WIDTH'(40);
   localparam logic [PARAM_WIDTH-1:0] SGR_BG_HI   = PARAM_WIDTH'(47);
   localparam logic [PARAM_WIDTH-1:0] SGR_FG_EXT  = PARAM_WIDTH'(38);
   localparam logic [PARAM_WIDTH-1:0] SGR_BG_EXT  = PARAM_WIDTH'(48);
   localparam logic [PARAM_WIDTH-1:0] SGR_SUB_256 = PARAM_WIDTH'(5);
   localparam logic [PARAM_WIDTH-1:0] SGR_SUB_RGB = PARAM_WIDTH'(2);

   // work handed from front to back: a text byte or a final letter with params
   typedef struct packed {
      logic                                         is_text;
      logic [7:0]                                   byte_val;
      logic [CNT_WIDTH-1:0]                         count;
      logic [DECODE_PARAMS-1:0][PARAM_WIDTH-1:0]    params;
   } job_type;

   // clamp a parameter value to the output field width
   function automatic logic [OUT_WIDTH-1:0] sat_out(input logic [PARAM_WIDTH-1:0] v);
      logic [PARAM_WIDTH+OUT_WIDTH-1:0] ext;
      logic [PARAM_WIDTH+OUT_WIDTH-1:0] lim;
      ext = {{OUT_WIDTH{1'b0}}, v};
      lim = {{PARAM_WIDTH{1'b0}}, {OUT_WIDTH{1'b1}}};
      if (ext > lim) begin
         return {OUT_WIDTH{1'b1}};
      end
      return ext[OUT_WIDTH-1:0];
   endfunction

endpackage

@@ hdl/acsp_front.sv @@
// front end: byte classifier, sequence state and parameter collection
`include "ansi_csi_sequence_parser_unit_macros.svh"

module acsp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [7:0]       req_in_byte,
   output logic             req_full,
   output logic             job_push,
   output acsp_pkg::job_type job_data,
   input  logic             job_full
);
   import acsp_pkg::*;

   typedef enum logic [1:0] {PH_GROUND, PH_ESC, PH_CSI} phase_type;

   phase_type                 phase_ff, phase_in;
   logic [CNT_WIDTH-1:0]      count_ff, count_in;
   logic [PARAM_WIDTH-1:0]    acc_ff, acc_in;
   logic                      nonempty_ff, nonempty_in;
   logic                      anybyte_ff, anybyte_in;
   logic [PARAM_WIDTH-1:0]    store_ff [MAX_PARAMS];

   logic                      accept;
   logic                      is_letter;
   logic                      is_digit;
   logic                      has_room;
   logic                      push_final;
   logic                      store_we;
   logic [PARAM_WIDTH+3:0]    acc_wide;
   logic [PARAM_WIDTH-1:0]    acc_sat;
   logic [CNT_WIDTH-1:0]      eff_count;
   logic [DECODE_PARAMS-1:0][PARAM_WIDTH-1:0] eff_params;

   assign accept   = req_push && !job_full;
   assign req_full = job_full;

   // byte classes
   assign is_letter = ((req_in_byte >= BYTE_UPPER_LO) && (req_in_byte <= BYTE_UPPER_HI)) ||
                      ((req_in_byte >= BYTE_LOWER_LO) && (req_in_byte <= BYTE_LOWER_HI));
   assign is_digit  = (req_in_byte >= BYTE_DIGIT_LO) && (req_in_byte <= BYTE_DIGIT_HI);

   // decimal accumulate with saturation
   assign acc_wide = ((PARAM_WIDTH+4)'(acc_ff) * (PARAM_WIDTH+4)'(10)) +
                     (PARAM_WIDTH+4)'(req_in_byte[3:0]);
   assign acc_sat  = (acc_wide > {4'b0000, {PARAM_WIDTH{1'b1}}}) ? {PARAM_WIDTH{1'b1}}
                                                                 : acc_wide[PARAM_WIDTH-1:0];

   assign has_room   = count_ff < CNT_WIDTH'(MAX_PARAMS);
   assign push_final = anybyte_ff && nonempty_ff;

   // parameters as seen by the final letter, pending part folded in
   always_comb begin
      eff_count = count_ff;
      if (push_final && has_room) begin
         eff_count = count_ff + CNT_WIDTH'(1);
      end
      for (int i = 0; i < DECODE_PARAMS; i++) begin
         eff_params[i] = (push_final && (count_ff == CNT_WIDTH'(i))) ? acc_ff : store_ff[i];
      end
   end

   // next state and job generation
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      acc_in      = acc_ff;
      nonempty_in = nonempty_ff;
      anybyte_in  = anybyte_ff;
      store_we    = 1'b0;
      job_push    = 1'b0;
      job_data.is_text  = 1'b0;
      job_data.byte_val = req_in_byte;
      job_data.count    = eff_count;
      job_data.params   = eff_params;
      if (accept) begin
         unique case (phase_ff)
            PH_ESC: begin
               if (req_in_byte == BYTE_LBRACKET) begin
                  phase_in    = PH_CSI;
                  count_in    = '0;
                  acc_in      = '0;
                  nonempty_in = 1'b0;
                  anybyte_in  = 1'b0;
               end else begin
                  phase_in = PH_GROUND;
               end
            end
            PH_CSI: begin
               if (is_letter) begin
                  job_push = 1'b1;
                  phase_in = PH_GROUND;
               end else begin
                  anybyte_in = 1'b1;
                  if (req_in_byte == BYTE_SEMI) begin
                     store_we    = has_room;
                     if (has_room) begin
                        count_in = count_ff + CNT_WIDTH'(1);
                     end
                     acc_in      = '0;
                     nonempty_in = 1'b0;
                  end else begin
                     nonempty_in = 1'b1;
                     if (is_digit) begin
                        acc_in = acc_sat;
                     end
                  end
               end
            end
            default: begin
               if (req_in_byte == BYTE_ESC) begin
                  phase_in = PH_ESC;
               end else begin
                  job_push         = 1'b1;
                  job_data.is_text = 1'b1;
               end
            end
         endcase
      end
   end

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_GROUND;
         count_ff    <= '0;
         acc_ff      <= '0;
         nonempty_ff <= 1'b0;
         anybyte_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         acc_ff      <= acc_in;
         nonempty_ff <= nonempty_in;
         anybyte_ff  <= anybyte_in;
      end
   end

   // parameter store, written at the current part index
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[count_ff[IDX_WIDTH-1:0]] <= acc_ff;
      end
   end

   // a job only comes from an accepted byte
   `ACSP_ASSERT_IMP(a_job_needs_accept, clock, reset, job_push, req_push && !job_full)
   // the byte after escape never makes a result
   `ACSP_ASSERT_IMP(a_esc_no_job, clock, reset, (phase_ff == PH_ESC) && accept, !job_push)

endmodule

@@ hdl/acsp_queue.sv @@
// two-entry job queue between front and back
`include "ansi_csi_sequence_parser_unit_macros.svh"

module acsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  acsp_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output acsp_pkg::job_type pop_data,
   output logic              empty
);
   import acsp_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ACSP_ASSERT_IMP(a_no_push_when_full, clock, reset, push, !full)
   `ACSP_ASSERT_IMP(a_no_pop_when_empty, clock, reset, pop, !empty)

endmodule

@@ hdl/acsp_back.sv @@
// back end: action decode and result register
module acsp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  acsp_pkg::job_type job_data,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_is_text,
   output logic [7:0]        rsp_text_byte,
   output logic [3:0]        rsp_action,
   output logic [15:0]       rsp_move_count,
   output logic [15:0]       rsp_row,
   output logic [15:0]       rsp_column,
   output logic [15:0]       rsp_color_index,
   output logic [15:0]       rsp_red,
   output logic [15:0]       rsp_green,
   output logic [15:0]       rsp_blue
);
   import acsp_pkg::*;

   typedef struct packed {
      logic                 is_text;
      logic [7:0]           text_byte;
      logic [3:0]           action;
      logic [OUT_WIDTH-1:0] move_count;
      logic [OUT_WIDTH-1:0] row;
      logic [OUT_WIDTH-1:0] column;
      logic [OUT_WIDTH-1:0] color_index;
      logic [OUT_WIDTH-1:0] red;
      logic [OUT_WIDTH-1:0] green;
      logic [OUT_WIDTH-1:0] blue;
   } rsp_type;

   rsp_type                rsp_ff, rsp_in;
   logic                   valid_ff, valid_in;
   logic [PARAM_WIDTH-1:0] mode;
   logic [PARAM_WIDTH-1:0] sub;
   logic                   ext_mode;

   // parameter with default when absent
   function automatic logic [PARAM_WIDTH-1:0] param_or(input job_type j, input int idx,
                                                       input logic [PARAM_WIDTH-1:0] dflt);
      if (j.count > CNT_WIDTH'(idx)) begin
         return j.params[idx];
      end
      return dflt;
   endfunction

   assign job_pop = !job_empty && (!valid_ff || rsp_pop);

   assign mode     = param_or(job_data, 0, '0);
   assign sub      = param_or(job_data, 1, '0);
   assign ext_mode = (mode == SGR_FG_EXT) || (mode == SGR_BG_EXT);

   // action decode
   always_comb begin
      rsp_in = '0;
      if (job_data.is_text) begin
         rsp_in.is_text   = 1'b1;
         rsp_in.text_byte = job_data.byte_val;
      end else begin
         rsp_in.action = ACT_UNKNOWN;
         unique case (job_data.byte_val)
            FIN_UP, FIN_DOWN, FIN_FWD, FIN_BACK: begin
               rsp_in.action     = 4'(job_data.byte_val - FIN_UP);
               rsp_in.move_count = sat_out(param_or(job_data, 0, PARAM_WIDTH'(1)));
            end
            FIN_POS, FIN_POS_ALT: begin
               rsp_in.action = ACT_SETPOS;
               rsp_in.row    = sat_out(param_or(job_data, 0, PARAM_WIDTH'(1)));
               rsp_in.column = sat_out(param_or(job_data, 1, PARAM_WIDTH'(1)));
            end
            FIN_CLRSCR:  rsp_in.action = ACT_CLRSCR;
            FIN_CLRLINE: rsp_in.action = ACT_CLRLINE;
            FIN_SGR: begin
               if ((job_data.count == '0) || (mode == SGR_OFF)) begin
                  rsp_in.action = ACT_RESET;
               end else if ((mode >= SGR_FG_LO) && (mode <= SGR_FG_HI)) begin
                  rsp_in.action      = ACT_FG;
                  rsp_in.color_index = sat_out(mode - SGR_FG_LO);
               end else if ((mode >= SGR_BG_LO) && (mode <= SGR_BG_HI)) begin
                  rsp_in.action      = ACT_BG;
                  rsp_in.color_index = sat_out(mode - SGR_BG_LO);
               end else if (ext_mode && (sub == SGR_SUB_256) &&
                            (job_data.count >= CNT_WIDTH'(3))) begin
                  rsp_in.action      = (mode == SGR_FG_EXT) ? ACT_FG256 : ACT_BG256;
                  rsp_in.color_index = sat_out(param_or(job_data, 2, '0));
               end else if (ext_mode && (sub == SGR_SUB_RGB) &&
                            (job_data.count >= CNT_WIDTH'(5))) begin
                  rsp_in.action = (mode == SGR_FG_EXT) ? ACT_FGRGB : ACT_BGRGB;
                  rsp_in.red    = sat_out(param_or(job_data, 2, '0));
                  rsp_in.green  = sat_out(param_or(job_data, 3, '0));
                  rsp_in.blue   = sat_out(param_or(job_data, 4, '0));
               end
            end
            default: rsp_in.action = ACT_UNKNOWN;
         endcase
      end
   end

   // result register valid flag
   always_comb begin
      valid_in = valid_ff;
      if (job_pop) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (job_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_is_text     = rsp_ff.is_text;
   assign rsp_text_byte   = rsp_ff.text_byte;
   assign rsp_action      = rsp_ff.action;
   assign rsp_move_count  = rsp_ff.move_count;
   assign rsp_row         = rsp_ff.row;
   assign rsp_column      = rsp_ff.column;
   assign rsp_color_index = rsp_ff.color_index;
   assign rsp_red         = rsp_ff.red;
   assign rsp_green       = rsp_ff.green;
   assign rsp_blue        = rsp_ff.blue;

endmodule

@@ hdl/ansi_csi_sequence_parser_unit.sv @@
// ansi csi parser: one byte in per cycle while req_full is low, results out through a register
// path: a byte's result passes the job queue and then the result register before it is on the ports
// throughput: one byte per cycle while the job queue is not full, set by the front state update
// (decimal multiply-add and parameter store write); results drain one per cycle while rsp_pop is high
// reset: synchronous active high; clears sequence state, job queue and result valid
// the parameter store is not cleared; it is only read below the part count
module ansi_csi_sequence_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_in_byte,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_is_text,
   output logic [7:0]  rsp_text_byte,
   output logic [3:0]  rsp_action,
   output logic [15:0] rsp_move_count,
   output logic [15:0] rsp_row,
   output logic [15:0] rsp_column,
   output logic [15:0] rsp_color_index,
   output logic [15:0] rsp_red,
   output logic [15:0] rsp_green,
   output logic [15:0] rsp_blue
);
   import acsp_pkg::*;

   logic    fq_push;
   job_type fq_push_data;
   logic    fq_full;
   logic    fq_pop;
   job_type fq_pop_data;
   logic    fq_empty;

   // classify bytes and collect parameters
   acsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .req_full    (req_full),
      .job_push    (fq_push),
      .job_data    (fq_push_data),
      .job_full    (fq_full)
   );

   // decouple front and back
   acsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_push_data),
      .full      (fq_full),
      .pop       (fq_pop),
      .pop_data  (fq_pop_data),
      .empty     (fq_empty)
   );

   // decode actions and hold results
   acsp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_empty       (fq_empty),
      .job_data        (fq_pop_data),
      .job_pop         (fq_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_is_text     (rsp_is_text),
      .rsp_text_byte   (rsp_text_byte),
      .rsp_action      (rsp_action),
      .rsp_move_count  (rsp_move_count),
      .rsp_row         (rsp_row),
      .rsp_column      (rsp_column),
      .rsp_color_index (rsp_color_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue)
   );

endmodule
